/* rtl/bpfs_pkg.sv */
`default_nettype none

package bpfs_pkg;

	localparam int COORD_W    = 16;
	localparam int VEC_W      = 17;
	localparam int UNIT_W     = 16;
	localparam int COLOR_W    = 8;
	localparam int LIT_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int SHININESS_DEF = 8;
	localparam int ONE_Q14       = 16384;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RGB = 3'd6;

	localparam logic [CFG_DATA_W-1:0] LIGHT_RGB_RST = 24'hFFFFFF;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [UNIT_W-1:0] unit_t;

endpackage

`default_nettype wire

/* rtl/blinn_phong_fragment_shade.sv */
`default_nettype none

// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  fragment: world xyz, normal xyz, base rgb
// m_*      out  m_tvalid/m_tready  lit rgb, Q2.10
// cfg_*    in   cfg_we             register index / write data
//
// One fragment per clock unless the output stalls. Most of the pipe is the two
// chained normalizers (32-step root, 16-step divide each).
// Reset clears valid bits and registers; the datapath carries no reset.
// When m_tvalid is high and m_tready low the whole pipe holds; s_tready drops.
module blinn_phong_fragment_shade #(
	parameter int SHININESS = bpfs_pkg::SHININESS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bpfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// world_x, world_y, world_z, normal_x, normal_y, normal_z,
	// base_red, base_green, base_blue
	input  wire logic [119:0]                    s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// lit_red, lit_green, lit_blue, 4 zero bits
	output logic [39:0]                          m_tdata
);

	localparam int VW  = bpfs_pkg::VEC_W;
	localparam int UW  = bpfs_pkg::UNIT_W;
	localparam int SBW = 3 * bpfs_pkg::COLOR_W;
	localparam int HBW = SBW + 6 * UW;
	localparam int AMB = 3277 * 256;

	logic en;

	logic signed [bpfs_pkg::COORD_W-1:0] lpos_q [3];
	logic signed [bpfs_pkg::COORD_W-1:0] cpos_q [3];
	logic [bpfs_pkg::CFG_DATA_W-1:0]     lrgb_q;

	logic signed [bpfs_pkg::COORD_W-1:0] w_in [3];
	logic signed [bpfs_pkg::COORD_W-1:0] n_in [3];

	bpfs_pkg::vec_t  va_t1 [9];
	logic [SBW-1:0]  base_t1;
	logic            v_t1;

	bpfs_pkg::unit_t ua [9];
	logic [SBW-1:0]  side_a;
	logic            va;

	bpfs_pkg::vec_t  hv_t2 [3];
	logic [HBW-1:0]  side_t2;
	logic            v_t2;

	bpfs_pkg::unit_t hu [3];
	logic [HBW-1:0]  side_b;
	logic            vb;

	logic signed [2*UW-1:0] pln_t3 [3];
	logic signed [2*UW-1:0] phn_t3 [3];
	logic [SBW-1:0]         base_t3;
	logic                   v_t3;

	logic [14:0]    sp_p [0:SHININESS];
	logic [14:0]    sp_h [0:SHININESS];
	logic [14:0]    sp_d [0:SHININESS];
	logic [SBW-1:0] sp_b [0:SHININESS];
	logic           sp_v [0:SHININESS];

	logic [22:0]    dl_c1 [3];
	logic [22:0]    sl_c1 [3];
	logic [SBW-1:0] base_c1;
	logic           v_c1;
	logic [23:0]    fac_c2 [3];
	logic [SBW-1:0] base_c2;
	logic           v_c2;
	logic [31:0]    prd_c3 [3];
	logic           v_c3;

	function automatic logic [14:0] clamp_dot(input logic signed [33:0] d);
		logic signed [33:0] r;
		r = (d + 34'sd8192) >>> 14;
		if (d <= 34'sd0) return '0;
		else if (r > 34'sd16384) return 15'(bpfs_pkg::ONE_Q14);
		else return r[14:0];
	endfunction

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				lpos_q[j] <= '0;
				cpos_q[j] <= '0;
			end
			lrgb_q <= bpfs_pkg::LIGHT_RGB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpfs_pkg::REG_LIGHT_X:   lpos_q[0] <= cfg_wdata[15:0];
				bpfs_pkg::REG_LIGHT_Y:   lpos_q[1] <= cfg_wdata[15:0];
				bpfs_pkg::REG_LIGHT_Z:   lpos_q[2] <= cfg_wdata[15:0];
				bpfs_pkg::REG_CAM_X:     cpos_q[0] <= cfg_wdata[15:0];
				bpfs_pkg::REG_CAM_Y:     cpos_q[1] <= cfg_wdata[15:0];
				bpfs_pkg::REG_CAM_Z:     cpos_q[2] <= cfg_wdata[15:0];
				bpfs_pkg::REG_LIGHT_RGB: lrgb_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			w_in[j] = s_tdata[16*j +: 16];
			n_in[j] = s_tdata[48 + 16*j +: 16];
		end
	end

	// light, view and normal vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				va_t1[j]   <= VW'(lpos_q[j]) - VW'(w_in[j]);
				va_t1[3+j] <= VW'(cpos_q[j]) - VW'(w_in[j]);
				va_t1[6+j] <= VW'(n_in[j]);
			end
			base_t1 <= s_tdata[119:96];
		end
	end

	bpfs_norm #(.NV(3), .SW(SBW)) u_norm_lvn (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_t1),
		.in_vec(va_t1), .in_side(base_t1),
		.out_valid(va), .out_unit(ua), .out_side(side_a)
	);

	// half vector
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				hv_t2[j] <= VW'(ua[j]) + VW'(ua[3+j]);
			end
			side_t2 <= {side_a, ua[0], ua[1], ua[2], ua[6], ua[7], ua[8]};
		end
	end

	bpfs_norm #(.NV(1), .SW(HBW)) u_norm_h (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_t2),
		.in_vec(hv_t2), .in_side(side_t2),
		.out_valid(vb), .out_unit(hu), .out_side(side_b)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pln_t3[j] <= $signed(side_b[6*UW-1-UW*j -: UW]) *
					$signed(side_b[3*UW-1-UW*j -: UW]);
				phn_t3[j] <= hu[j] * $signed(side_b[3*UW-1-UW*j -: UW]);
			end
			base_t3 <= side_b[HBW-1 -: SBW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_d[0] <= clamp_dot(34'(pln_t3[0]) + 34'(pln_t3[1]) + 34'(pln_t3[2]));
			sp_h[0] <= clamp_dot(34'(phn_t3[0]) + 34'(phn_t3[1]) + 34'(phn_t3[2]));
			sp_p[0] <= 15'(bpfs_pkg::ONE_Q14);
			sp_b[0] <= base_t3;
		end
	end

	// specular power, one multiply per stage
	for (genvar k = 0; k < SHININESS; k++) begin : g_pow
		always_ff @(posedge clk) begin
			if (en) begin
				sp_p[k+1] <= 15'((30'(sp_p[k]) * 30'(sp_h[k]) + 30'd8192) >> 14);
				sp_h[k+1] <= sp_h[k];
				sp_d[k+1] <= sp_d[k];
				sp_b[k+1] <= sp_b[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sp_v[k+1] <= 1'b0;
			end else if (en) begin
				sp_v[k+1] <= sp_v[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dl_c1[i] <= 23'(sp_d[SHININESS]) * 23'(lrgb_q[16-8*i +: 8]);
				sl_c1[i] <= 23'(sp_p[SHININESS]) * 23'(lrgb_q[16-8*i +: 8]);
				fac_c2[i] <= 24'(AMB) + 24'(dl_c1[i]) + 24'(sl_c1[i]);
				prd_c3[i] <= 32'(base_c2[8*i +: 8]) * 32'(fac_c2[i]);
			end
			base_c1 <= sp_b[SHININESS];
			base_c2 <= base_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (((33'(prd_c3[i]) + 33'h80000) >> 20) > 33'd4095) begin
					m_tdata[12*i +: 12] <= 12'hFFF;
				end else begin
					m_tdata[12*i +: 12] <= 12'((33'(prd_c3[i]) + 33'h80000) >> 20);
				end
			end
			m_tdata[39:36] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1     <= 1'b0;
			v_t2     <= 1'b0;
			v_t3     <= 1'b0;
			sp_v[0]  <= 1'b0;
			v_c1     <= 1'b0;
			v_c2     <= 1'b0;
			v_c3     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_t1     <= s_tvalid;
			v_t2     <= va;
			v_t3     <= vb;
			sp_v[0]  <= v_t3;
			v_c1     <= sp_v[SHININESS];
			v_c2     <= v_c1;
			v_c3     <= v_c2;
			m_tvalid <= v_c3;
		end
	end

endmodule

`default_nettype wire

/* rtl/bpfs_norm.sv */
`default_nettype none

// Pipelined vector normalizer: squares, length, 32-step square root,
// 16-step restoring divide per component, clamp and sign. Q1.14 result.
module bpfs_norm #(
	parameter int NV = 3,
	parameter int SW = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire bpfs_pkg::vec_t in_vec [NV*3],
	input  wire logic [SW-1:0]  in_side,
	output logic                out_valid,
	output bpfs_pkg::unit_t     out_unit [NV*3],
	output logic [SW-1:0]       out_side
);

	localparam int NC   = NV * 3;
	localparam int MW   = bpfs_pkg::VEC_W;
	localparam int SQW  = 2 * MW;
	localparam int LW   = SQW + 2;
	localparam int FRAC = 28;
	localparam int XW   = LW + FRAC;
	localparam int NSQ  = XW / 2;
	localparam int SRW  = XW / 2;
	localparam int QW   = 16;
	localparam int RW   = SRW + QW - 1;
	localparam int LAT  = 4 + NSQ + QW;

	typedef struct packed {
		logic                 zero;
		logic [2:0]           neg;
		logic [2:0][MW-1:0]   mag;
	} vinfo_t;

	logic [MW-1:0]  mag_in [NC];
	logic [SQW-1:0] sqr_s1 [NC];
	vinfo_t         inf_s1 [NV];

	logic [XW-1:0]  sx_s   [0:NSQ][NV];
	logic [XW-1:0]  sr_s   [0:NSQ][NV];
	vinfo_t         sinf_s [0:NSQ][NV];

	logic [RW-1:0]  rem_s  [0:QW][NC];
	logic [QW-1:0]  quo_s  [0:QW][NC];
	logic [SRW-1:0] den_s  [0:QW][NV];
	vinfo_t         dinf_s [0:QW][NV];

	logic [LAT-1:0] vld_q;
	logic [SW-1:0]  side_q [LAT];

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			mag_in[c] = in_vec[c][MW-1] ? MW'(-in_vec[c]) : MW'(in_vec[c]);
		end
	end

	// squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NC; c++) begin
				sqr_s1[c] <= SQW'(mag_in[c]) * SQW'(mag_in[c]);
			end
			for (int v = 0; v < NV; v++) begin
				inf_s1[v].zero <= (mag_in[3*v] == '0) && (mag_in[3*v+1] == '0) &&
					(mag_in[3*v+2] == '0);
				for (int j = 0; j < 3; j++) begin
					inf_s1[v].neg[j] <= in_vec[3*v+j][MW-1];
					inf_s1[v].mag[j] <= mag_in[3*v+j];
				end
			end
		end
	end

	// length squared, scaled for the root
	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < NV; v++) begin
				sx_s[0][v] <= {LW'(sqr_s1[3*v]) + LW'(sqr_s1[3*v+1]) + LW'(sqr_s1[3*v+2]),
					FRAC'(0)};
				sr_s[0][v] <= '0;
				sinf_s[0][v] <= inf_s1[v];
			end
		end
	end

	// one result bit per stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * k);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int v = 0; v < NV; v++) begin
					if (sx_s[k][v] >= sr_s[k][v] + BIT) begin
						sx_s[k+1][v] <= sx_s[k][v] - (sr_s[k][v] + BIT);
						sr_s[k+1][v] <= (sr_s[k][v] >> 1) + BIT;
					end else begin
						sx_s[k+1][v] <= sx_s[k][v];
						sr_s[k+1][v] <= sr_s[k][v] >> 1;
					end
					sinf_s[k+1][v] <= sinf_s[k][v];
				end
			end
		end
	end

	// rounded numerator
	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < NV; v++) begin
				den_s[0][v] <= sr_s[NSQ][v][SRW-1:0];
				dinf_s[0][v] <= sinf_s[NSQ][v];
				for (int j = 0; j < 3; j++) begin
					rem_s[0][3*v+j] <= RW'({sinf_s[NSQ][v].mag[j], FRAC'(0)}) +
						RW'(sr_s[NSQ][v][SRW-1:0] >> 1);
					quo_s[0][3*v+j] <= '0;
				end
			end
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int SH = QW - 1 - i;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int v = 0; v < NV; v++) begin
					den_s[i+1][v] <= den_s[i][v];
					dinf_s[i+1][v] <= dinf_s[i][v];
					for (int j = 0; j < 3; j++) begin
						if (rem_s[i][3*v+j] >= (RW'(den_s[i][v]) << SH)) begin
							rem_s[i+1][3*v+j] <= rem_s[i][3*v+j] - (RW'(den_s[i][v]) << SH);
							quo_s[i+1][3*v+j] <= quo_s[i][3*v+j] | (QW'(1) << SH);
						end else begin
							rem_s[i+1][3*v+j] <= rem_s[i][3*v+j];
							quo_s[i+1][3*v+j] <= quo_s[i][3*v+j];
						end
					end
				end
			end
		end
	end

	// clamp to one, restore sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < NV; v++) begin
				for (int j = 0; j < 3; j++) begin
					if (dinf_s[QW][v].zero) begin
						out_unit[3*v+j] <= '0;
					end else if (quo_s[QW][3*v+j] > QW'(bpfs_pkg::ONE_Q14)) begin
						out_unit[3*v+j] <= dinf_s[QW][v].neg[j] ?
							-bpfs_pkg::UNIT_W'(bpfs_pkg::ONE_Q14) :
							bpfs_pkg::UNIT_W'(bpfs_pkg::ONE_Q14);
					end else begin
						out_unit[3*v+j] <= dinf_s[QW][v].neg[j] ?
							-bpfs_pkg::unit_t'(quo_s[QW][3*v+j]) :
							bpfs_pkg::unit_t'(quo_s[QW][3*v+j]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			for (int k = 1; k < LAT; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign out_valid = vld_q[LAT-1];
	assign out_side  = side_q[LAT-1];

endmodule

`default_nettype wire

/* verif/bpfs_checker.sv */
`default_nettype none

module bpfs_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bpfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [119:0]                    s_tdata,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [39:0]                     m_tdata,
	output int                                   fails,
	output int                                   pending
);

	localparam longint AMBIENT = 3277;
	localparam int     SHINE   = bpfs_pkg::SHININESS_DEF;
	localparam longint ONE     = bpfs_pkg::ONE_Q14;

	typedef struct {
		longint x;
		longint y;
		longint z;
	} v3_t;

	logic signed [15:0] light_pos [3];
	logic signed [15:0] cam_pos [3];
	logic [23:0]        light_rgb;
	logic [35:0]        lit_q [$];

	function automatic longint unsigned isqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned absv(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Q1.14 unit vector; zero length gives the zero vector
	function automatic v3_t unit_of(input v3_t v);
		v3_t u;
		longint unsigned len2, s, q, m;
		longint c [3];
		longint o [3];
		c[0] = v.x; c[1] = v.y; c[2] = v.z;
		len2 = 0;
		for (int i = 0; i < 3; i++) len2 += absv(c[i]) * absv(c[i]);
		if (len2 == 0) begin
			u.x = 0; u.y = 0; u.z = 0;
			return u;
		end
		s = isqrt(len2 << 28);
		for (int i = 0; i < 3; i++) begin
			m = absv(c[i]);
			q = ((m << 28) + (s >> 1)) / s;
			if (q > ONE) q = ONE;
			o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
		end
		u.x = o[0]; u.y = o[1]; u.z = o[2];
		return u;
	endfunction

	function automatic longint clamped_dot(input v3_t a, input v3_t b);
		longint d, r;
		d = a.x * b.x + a.y * b.y + a.z * b.z;
		if (d <= 0) return 0;
		r = (d + 8192) >>> 14;
		return (r > ONE) ? ONE : r;
	endfunction

	function automatic logic [35:0] shade(input logic [119:0] d);
		v3_t w, nv, lv, vv, hv, lu, vu, nu, hu;
		longint diff, hdot, spec, base, lc, factor, c;
		logic [35:0] res;
		w.x  = longint'($signed(d[15:0]));
		w.y  = longint'($signed(d[31:16]));
		w.z  = longint'($signed(d[47:32]));
		nv.x = longint'($signed(d[63:48]));
		nv.y = longint'($signed(d[79:64]));
		nv.z = longint'($signed(d[95:80]));
		lv.x = longint'(light_pos[0]) - w.x;
		lv.y = longint'(light_pos[1]) - w.y;
		lv.z = longint'(light_pos[2]) - w.z;
		vv.x = longint'(cam_pos[0]) - w.x;
		vv.y = longint'(cam_pos[1]) - w.y;
		vv.z = longint'(cam_pos[2]) - w.z;
		lu = unit_of(lv);
		vu = unit_of(vv);
		nu = unit_of(nv);
		hv.x = lu.x + vu.x;
		hv.y = lu.y + vu.y;
		hv.z = lu.z + vu.z;
		hu = unit_of(hv);
		diff = clamped_dot(lu, nu);
		hdot = clamped_dot(hu, nu);
		spec = ONE;
		for (int i = 0; i < SHINE; i++) spec = (spec * hdot + 8192) >>> 14;
		for (int i = 0; i < 3; i++) begin
			base = longint'(d[96 + 8*i +: 8]);
			lc = longint'(light_rgb[16 - 8*i +: 8]);
			factor = AMBIENT * 256 + diff * lc + spec * lc;
			c = (base * factor + (64'sd1 <<< 19)) >>> 20;
			if (c > 4095) c = 4095;
			res[12*i +: 12] = c[11:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				light_pos[i] <= '0;
				cam_pos[i] <= '0;
			end
			light_rgb <= bpfs_pkg::LIGHT_RGB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpfs_pkg::REG_LIGHT_X:   light_pos[0] <= cfg_wdata[15:0];
				bpfs_pkg::REG_LIGHT_Y:   light_pos[1] <= cfg_wdata[15:0];
				bpfs_pkg::REG_LIGHT_Z:   light_pos[2] <= cfg_wdata[15:0];
				bpfs_pkg::REG_CAM_X:     cam_pos[0] <= cfg_wdata[15:0];
				bpfs_pkg::REG_CAM_Y:     cam_pos[1] <= cfg_wdata[15:0];
				bpfs_pkg::REG_CAM_Z:     cam_pos[2] <= cfg_wdata[15:0];
				bpfs_pkg::REG_LIGHT_RGB: light_rgb <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		logic [35:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready) lit_q = {lit_q, shade(s_tdata)};
			if (m_tvalid && m_tready) begin
				if (lit_q.size() == 0) begin
					$error("result with no fragment pending: %h", m_tdata);
					fails++;
				end else begin
					want = lit_q.pop_front();
					if (m_tdata[11:0] !== want[11:0]) begin
						$error("lit_red exp %0d got %0d", want[11:0], m_tdata[11:0]);
						fails++;
					end
					if (m_tdata[23:12] !== want[23:12]) begin
						$error("lit_green exp %0d got %0d", want[23:12], m_tdata[23:12]);
						fails++;
					end
					if (m_tdata[35:24] !== want[35:24]) begin
						$error("lit_blue exp %0d got %0d", want[35:24], m_tdata[35:24]);
						fails++;
					end
				end
			end
			pending <= lit_q.size();
		end
	end

endmodule

`default_nettype wire

/* verif/tb.sv */
`default_nettype none

module tb;

	localparam int LATENCY  = 112 + bpfs_pkg::SHININESS_DEF;
	localparam int WD_LIMIT = 3000;
	localparam int HOLD_AT  = 420;

	// index past the last register
	localparam logic [bpfs_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bpfs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bpfs_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [119:0]                    s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [39:0]                     m_tdata;
	int                              fails;
	int                              pending;

	int                              n_sent;
	int                              idle_cycles;
	bit                              calm;
	bit                              held;
	logic [15:0]                     cur_light [3];

	blinn_phong_fragment_shade u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	bpfs_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fails(fails), .pending(pending)
	);

	always #5 clk = ~clk;

	function automatic logic [119:0] frag(input logic [15:0] wx, wy, wz, nx, ny, nz,
			input logic [7:0] r, g, b);
		return {b, g, r, nz, ny, nx, wz, wy, wx};
	endfunction

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [15:0] near();
		return 16'($signed($urandom_range(0, 4095)) - 2048);
	endfunction

	task automatic send(input logic [119:0] d);
		int  gap;
		bit  ok;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		n_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic reg_write(input logic [bpfs_pkg::CFG_IDX_W-1:0] idx,
			input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == bpfs_pkg::REG_LIGHT_X) cur_light[0] = val[15:0];
		if (idx == bpfs_pkg::REG_LIGHT_Y) cur_light[1] = val[15:0];
		if (idx == bpfs_pkg::REG_LIGHT_Z) cur_light[2] = val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_scene(input logic [15:0] lx, ly, lz, cx, cy, cz, input logic [23:0] rgb);
		reg_write(bpfs_pkg::REG_LIGHT_X, {8'h00, lx});
		reg_write(bpfs_pkg::REG_LIGHT_Y, {8'h00, ly});
		reg_write(bpfs_pkg::REG_LIGHT_Z, {8'h00, lz});
		reg_write(bpfs_pkg::REG_CAM_X, {8'h00, cx});
		reg_write(bpfs_pkg::REG_CAM_Y, {8'h00, cy});
		reg_write(bpfs_pkg::REG_CAM_Z, {8'h00, cz});
		reg_write(bpfs_pkg::REG_LIGHT_RGB, rgb);
	endtask

	task automatic random_frags(input int n);
		int          mode;
		logic [15:0] w [3];
		logic [15:0] nrm [3];
		for (int k = 0; k < n; k++) begin
			mode = $urandom_range(0, 9);
			for (int i = 0; i < 3; i++) begin
				w[i] = near();
				nrm[i] = 16'($signed($urandom_range(0, 8191)) - 4096);
			end
			case (mode)
				0: for (int i = 0; i < 3; i++) begin
					w[i] = 16'($urandom);
					nrm[i] = 16'($urandom);
				end
				1: for (int i = 0; i < 3; i++) nrm[i] = '0;
				2: w = cur_light;
				default: ;
			endcase
			send(frag(w[0], w[1], w[2], nrm[0], nrm[1], nrm[2],
				8'($urandom), 8'($urandom), 8'($urandom)));
		end
	endtask

	// receiver: random stalls, one long hold-off to back the pipe up
	initial begin
		int w;
		bit ok;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && n_sent >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			w = draw_gap();
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				ok = m_tvalid;
				@(posedge clk);
			end while (!ok);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		n_sent = 0;
		calm = 1'b0;
		cur_light[0] = '0;
		cur_light[1] = '0;
		cur_light[2] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset scene: light and camera at origin
		calm = 1'b1;
		send(frag(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'hFF, 8'hFF, 8'hFF));
		send(frag(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF, 8'hFF, 8'h80, 8'h00));
		send(frag(16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF));
		send(frag(16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h8000, 8'hFF, 8'hFF, 8'hFF));
		send(frag(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
			8'hFF, 8'h01, 8'h00));
		send(frag(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			8'h00, 8'h00, 8'h00));
		send(frag(16'h8000, 16'h7FFF, 16'h0001, 16'h0001, 16'h0, 16'h0, 8'hAA, 8'h55, 8'hFF));
		send(frag(16'hFF00, 16'h0, 16'h0, 16'h0001, 16'h0001, 16'h0001, 8'h55, 8'hAA, 8'h01));
		send(frag(16'h0, 16'hFF00, 16'h0, 16'h0, 16'h7FFF, 16'h0, 8'hFF, 8'hFF, 8'hFF));
		send(frag(16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0001, 8'hFF, 8'hFF, 8'hFF));
		calm = 1'b0;
		drain();

		// light overhead, camera in front
		set_scene(16'h0A00, 16'h0A00, 16'h0A00, 16'h0, 16'h0, 16'h1400, 24'hFFFFFF);
		send(frag(16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100, 8'hFF, 8'hFF, 8'hFF));
		send(frag(16'h0A00, 16'h0A00, 16'h0A00, 16'h0, 16'h0, 16'h0100, 8'hFF, 8'hFF, 8'hFF));
		send(frag(16'h0, 16'h0, 16'h1400, 16'h0, 16'h0, 16'h0100, 8'h80, 8'h80, 8'h80));
		send(frag(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'hFF, 8'hFF, 8'hFF));
		drain();
		// light opposite the camera: half vector vanishes
		reg_write(bpfs_pkg::REG_LIGHT_X, 24'h0);
		reg_write(bpfs_pkg::REG_LIGHT_Y, 24'h0);
		reg_write(bpfs_pkg::REG_LIGHT_Z, 24'h00EC00);
		send(frag(16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 8'hFF, 8'hFF, 8'hFF));
		send(frag(16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0100, 8'hFF, 8'hFF, 8'hFF));
		drain();
		set_scene(16'h0A00, 16'h0A00, 16'h0A00, 16'h0, 16'h0, 16'h1400, 24'hFFFFFF);
		random_frags(150);
		drain();

		// extremes; an index past the last register must be ignored
		set_scene(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 24'h000000);
		reg_write(REG_NONE, 24'hFFFFFF);
		random_frags(40);
		drain();
		set_scene(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'hFF00FF);
		random_frags(40);
		drain();

		// back-to-back burst; receiver holds off partway through
		set_scene(near(), near(), near(), near(), near(), near(), 24'($urandom));
		calm = 1'b1;
		random_frags(200);
		calm = 1'b0;
		drain();

		set_scene(16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
		random_frags(80);
		drain();
		set_scene(near(), near(), near(), near(), near(), near(), 24'h00FF00);
		random_frags(90);
		drain();

		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* blinn_phong_fragment_shade.f */
rtl/bpfs_pkg.sv
rtl/bpfs_norm.sv
rtl/blinn_phong_fragment_shade.sv
verif/bpfs_checker.sv
verif/tb.sv
